// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for concurrent checks on the clk / rst domain
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is off while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also watches the reset cycles
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/gpw_pkg.sv -----
// ----------------------------------------------------------------------------
// gpw_pkg
// shared types and constants of the gaussian projection weight pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpw_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_DIMS    = 2'd0;
  localparam logic [1:0] REG_WIDTH_X = 2'd1;
  localparam logic [1:0] REG_WIDTH_Y = 2'd2;
  localparam logic [1:0] REG_WIDTH_Z = 2'd3;

  localparam logic [1:0]  DIMS_2D     = 2'd2;
  localparam logic [31:0] WIDTH_RESET = 32'h0001_0000;

  // ratio divider: quotient bits 32..0 of (|d| << 28) / w
  localparam int          RATIO_STEPS = 33;
  localparam int          RATIO_FRAC  = 28;
  localparam int          MAG_STAGES  = RATIO_STEPS - RATIO_FRAC;
  localparam logic [32:0] RATIO_CAP   = 33'h0_8000_0000;

  // exponential
  localparam logic [31:0] LN2_Q32      = 32'hB172_17F8;
  localparam int          EXP_N_BITS   = 9;
  localparam int          EXP_N_STAGES = 3;
  localparam int          HORNER_TERMS = 12;
  localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;

  // floor(2^32 / k), k = 1 .. 12
  localparam logic [32:0] RECIP_Q32 [1:HORNER_TERMS] = '{
    33'h1_0000_0000, 33'h0_8000_0000, 33'd1431655765, 33'h0_4000_0000,
    33'd858993459,   33'd715827882,   33'd613566756,  33'h0_2000_0000,
    33'd477218588,   33'd429496729,   33'd390451572,  33'd357913941
  };

  // normalization: 2^32 / pi and 2^32 / pi^1.5
  localparam logic [30:0] INV_PI_2D = 31'd1367130551;
  localparam logic [30:0] INV_PI_3D = 31'd771320817;

  localparam int          QUOT_BITS  = 48;
  localparam logic [47:0] WEIGHT_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        two_d;
    logic [31:0] width_x;
    logic [31:0] width_y;
    logic [31:0] width_z;
  } gpw_cfg_t;

  typedef struct packed {
    logic valid;
    logic two_d;
  } item_tag_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gpw_ratio.sv -----
// ----------------------------------------------------------------------------
// gpw_ratio
// per-axis (d / w)^2 with a pipelined restoring divider, summed over axes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpw_ratio import gpw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  item_tag_t   tag_in,
  input  logic [31:0] offset_x,
  input  logic [31:0] offset_y,
  input  logic [31:0] offset_z,
  input  gpw_cfg_t    cfg,
  output item_tag_t   tag_out,
  output logic [39:0] sum_sq
);

  localparam int NAX = 3;

  logic [31:0] wdt [NAX];
  logic [31:0] off [NAX];

  assign wdt[0] = cfg.width_x;
  assign wdt[1] = cfg.width_y;
  assign wdt[2] = cfg.width_z;
  assign off[0] = offset_x;
  assign off[1] = offset_y;
  assign off[2] = offset_z;

  item_tag_t   tag_p [RATIO_STEPS+1];
  logic [31:0] mag_p [MAG_STAGES][NAX];
  logic [31:0] rem_p [RATIO_STEPS][NAX];
  logic [32:0] quo_p [RATIO_STEPS+1][NAX];
  logic        ovf_p [RATIO_STEPS+1][NAX];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_p[0] <= '0;
    end else if (adv) begin
      tag_p[0] <= tag_in;
    end
  end

  for (genvar a = 0; a < NAX; a++) begin : g_entry
    logic [31:0] mag;
    assign mag = off[a][31] ? (~off[a] + 32'd1) : off[a];
    always_ff @(posedge clk) begin
      if (adv) begin
        mag_p[0][a] <= mag;
        rem_p[0][a] <= {5'b0, mag[31:5]};
        quo_p[0][a] <= '0;
        // quotient would not fit in 33 bits
        ovf_p[0][a] <= ({5'b0, mag[31:5]} >= wdt[a]);
      end
    end
  end

  for (genvar s = 0; s < RATIO_STEPS; s++) begin : g_step
    localparam int BI = RATIO_STEPS - 1 - s;

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_p[s+1] <= '0;
      end else if (adv) begin
        tag_p[s+1] <= tag_p[s];
      end
    end

    for (genvar a = 0; a < NAX; a++) begin : g_ax
      logic        nb;
      logic        ge;
      logic [32:0] sh;
      logic [32:0] diff;

      if (BI >= RATIO_FRAC) begin : g_bit
        assign nb = mag_p[s][a][BI-RATIO_FRAC];
      end else begin : g_zero
        assign nb = 1'b0;
      end

      assign sh   = {rem_p[s][a], nb};
      assign ge   = (sh >= {1'b0, wdt[a]});
      assign diff = sh - {1'b0, wdt[a]};

      always_ff @(posedge clk) begin
        if (adv) begin
          quo_p[s+1][a] <= {quo_p[s][a][31:0], ge};
          ovf_p[s+1][a] <= ovf_p[s][a];
        end
      end

      if (s + 1 < RATIO_STEPS) begin : g_rem
        always_ff @(posedge clk) begin
          if (adv) begin
            rem_p[s+1][a] <= ge ? diff[31:0] : sh[31:0];
          end
        end
      end

      if (s + 1 < MAG_STAGES) begin : g_mag
        always_ff @(posedge clk) begin
          if (adv) begin
            mag_p[s+1][a] <= mag_p[s][a];
          end
        end
      end
    end
  end

  item_tag_t   tag_r;
  item_tag_t   tag_sq;
  logic [31:0] ratio [NAX];
  logic [38:0] sq    [NAX];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_r   <= '0;
      tag_sq  <= '0;
      tag_out <= '0;
    end else if (adv) begin
      tag_r   <= tag_p[RATIO_STEPS];
      tag_sq  <= tag_r;
      tag_out <= tag_sq;
    end
  end

  for (genvar a = 0; a < NAX; a++) begin : g_square
    logic [63:0] prod;
    assign prod = {32'b0, ratio[a]} * {32'b0, ratio[a]};
    always_ff @(posedge clk) begin
      if (adv) begin
        // ratio clamps at 8.0
        ratio[a] <= (ovf_p[RATIO_STEPS][a] || quo_p[RATIO_STEPS][a] > RATIO_CAP) ?
                    RATIO_CAP[31:0] : quo_p[RATIO_STEPS][a][31:0];
        sq[a]    <= prod[62:24];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_sq <= {1'b0, sq[0]} + {1'b0, sq[1]} + (tag_sq.two_d ? 40'd0 : {1'b0, sq[2]});
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gpw_exp.sv -----
// ----------------------------------------------------------------------------
// gpw_exp
// exp(-s) in q.32: ln2 range reduction, then a pipelined horner chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpw_exp import gpw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  item_tag_t   tag_in,
  input  logic [39:0] sum_sq,
  output item_tag_t   tag_out,
  output logic [32:0] expo
);

  localparam int N_PER = EXP_N_BITS / EXP_N_STAGES;

  // ---- n = s / ln2, three quotient bits per stage
  item_tag_t             nd_tag [1:EXP_N_STAGES];
  logic [31:0]           nd_rem [1:EXP_N_STAGES];
  logic [EXP_N_BITS-1:0] nd_q   [1:EXP_N_STAGES];
  logic [EXP_N_BITS-1:0] nd_s   [1:EXP_N_STAGES-1];

  for (genvar j = 0; j < EXP_N_STAGES; j++) begin : g_ndiv
    item_tag_t             tag_i;
    logic [31:0]           rem_i;
    logic [31:0]           rem_o;
    logic [EXP_N_BITS-1:0] q_i;
    logic [EXP_N_BITS-1:0] q_o;
    logic [EXP_N_BITS-1:0] s_i;

    if (j == 0) begin : g_first
      assign tag_i = tag_in;
      assign rem_i = {1'b0, sum_sq[39:EXP_N_BITS]};
      assign q_i   = '0;
      assign s_i   = sum_sq[EXP_N_BITS-1:0];
    end else begin : g_next
      assign tag_i = nd_tag[j];
      assign rem_i = nd_rem[j];
      assign q_i   = nd_q[j];
      assign s_i   = nd_s[j];
    end

    always_comb begin : p_steps
      logic [32:0] sh;
      logic        ge;
      rem_o = rem_i;
      q_o   = q_i;
      for (int t = 0; t < N_PER; t++) begin
        sh    = {rem_o, s_i[EXP_N_BITS-1-(j*N_PER+t)]};
        ge    = (sh >= {1'b0, LN2_Q32});
        rem_o = ge ? 32'(sh - {1'b0, LN2_Q32}) : sh[31:0];
        q_o   = {q_o[EXP_N_BITS-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        nd_tag[j+1] <= '0;
      end else if (adv) begin
        nd_tag[j+1] <= tag_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        nd_rem[j+1] <= rem_o;
        nd_q[j+1]   <= q_o;
      end
    end

    if (j + 1 < EXP_N_STAGES) begin : g_keep
      always_ff @(posedge clk) begin
        if (adv) begin
          nd_s[j+1] <= s_i;
        end
      end
    end
  end

  // ---- horner: acc = 1 - (rem * acc) / k, k = 12 down to 1, three stages a term
  item_tag_t             hz_tag [1:HORNER_TERMS];
  logic [31:0]           hz_rem [1:HORNER_TERMS-1];
  logic [EXP_N_BITS-1:0] hz_n   [1:HORNER_TERMS];
  logic [32:0]           hz_acc [1:HORNER_TERMS];

  for (genvar h = 0; h < HORNER_TERMS; h++) begin : g_horner
    localparam int K = HORNER_TERMS - h;

    item_tag_t             tag_i;
    logic [31:0]           rem_i;
    logic [EXP_N_BITS-1:0] n_i;
    logic [32:0]           acc_i;

    item_tag_t             tag_a;
    item_tag_t             tag_b;
    logic [31:0]           rem_a;
    logic [31:0]           rem_b;
    logic [EXP_N_BITS-1:0] n_a;
    logic [EXP_N_BITS-1:0] n_b;
    logic [31:0]           x_a;
    logic [31:0]           x_b;
    logic [31:0]           q0_b;
    logic [64:0]           prod_a;
    logic [64:0]           prod_b;
    logic [31:0]           qk;
    logic [31:0]           resid;
    logic [31:0]           quo;

    if (h == 0) begin : g_first
      assign tag_i = nd_tag[EXP_N_STAGES];
      assign rem_i = nd_rem[EXP_N_STAGES];
      assign n_i   = nd_q[EXP_N_STAGES];
      assign acc_i = ONE_Q32;
    end else begin : g_next
      assign tag_i = hz_tag[h];
      assign rem_i = hz_rem[h];
      assign n_i   = hz_n[h];
      assign acc_i = hz_acc[h];
    end

    assign prod_a = {33'b0, rem_i} * {32'b0, acc_i};
    assign prod_b = {33'b0, x_a} * {32'b0, RECIP_Q32[K]};

    // reciprocal estimate is low by at most one
    assign qk    = q0_b * 32'(K);
    assign resid = x_b - qk;
    assign quo   = (resid >= 32'(K)) ? q0_b + 32'd1 : q0_b;

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_a       <= '0;
        tag_b       <= '0;
        hz_tag[h+1] <= '0;
      end else if (adv) begin
        tag_a       <= tag_i;
        tag_b       <= tag_a;
        hz_tag[h+1] <= tag_b;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_a       <= rem_i;
        n_a         <= n_i;
        x_a         <= prod_a[63:32];
        rem_b       <= rem_a;
        n_b         <= n_a;
        x_b         <= x_a;
        q0_b        <= prod_b[63:32];
        hz_n[h+1]   <= n_b;
        hz_acc[h+1] <= ONE_Q32 - {1'b0, quo};
      end
    end

    if (h + 1 < HORNER_TERMS) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          hz_rem[h+1] <= rem_b;
        end
      end
    end
  end

  // ---- scale by 2^-n
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (adv) begin
      tag_out <= hz_tag[HORNER_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      expo <= (|hz_n[HORNER_TERMS][EXP_N_BITS-1:6]) ? 33'd0 :
              hz_acc[HORNER_TERMS] >> hz_n[HORNER_TERMS][5:0];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gpw_norm_div.sv -----
// ----------------------------------------------------------------------------
// gpw_norm_div
// normalization by 1/pi^(D/2) and a pipelined divide by the width product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpw_norm_div import gpw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  item_tag_t   tag_in,
  input  logic [32:0] expo,
  input  gpw_cfg_t    cfg,
  output logic        out_valid,
  output logic [47:0] weight,
  output logic        saturated
);

  // ---- width product, follows the configuration through the p_xy, p_lo / p_hi, p_xyz and divisor registers
  logic [63:0] p_xy;
  logic [63:0] p_lo;
  logic [63:0] p_hi;
  logic [95:0] p_xyz;
  logic [95:0] divisor;

  always_ff @(posedge clk) begin
    p_xy    <= {32'b0, cfg.width_x} * {32'b0, cfg.width_y};
    p_lo    <= {32'b0, p_xy[31:0]} * {32'b0, cfg.width_z};
    p_hi    <= {32'b0, p_xy[63:32]} * {32'b0, cfg.width_z};
    p_xyz   <= {p_hi, 32'b0} + {32'b0, p_lo};
    divisor <= cfg.two_d ? {32'b0, p_xy} : p_xyz;
  end

  // ---- normalization multiply
  item_tag_t   tag_a;
  logic [63:0] a_r;
  logic [30:0] cnorm;

  assign cnorm = tag_in.two_d ? INV_PI_2D : INV_PI_3D;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
    end else if (adv) begin
      tag_a <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= {31'b0, expo} * {33'b0, cnorm};
    end
  end

  // ---- restoring divider, one quotient bit per stage
  logic [79:0] num;
  logic        ovf0;

  assign num  = tag_a.two_d ? {16'b0, a_r} : {a_r, 16'b0};
  assign ovf0 = (divisor[95:32] == '0) && (num[79:48] >= divisor[31:0]);

  item_tag_t              d_tag [QUOT_BITS+1];
  logic [95:0]            d_rem [QUOT_BITS];
  logic [QUOT_BITS-1:0]   d_nlo [QUOT_BITS];
  logic [QUOT_BITS-1:0]   d_q   [QUOT_BITS+1];
  logic                   d_ovf [QUOT_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_tag[0] <= '0;
    end else if (adv) begin
      d_tag[0] <= tag_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_rem[0] <= {64'b0, num[79:48]};
      d_nlo[0] <= num[QUOT_BITS-1:0];
      d_q[0]   <= '0;
      d_ovf[0] <= ovf0;
    end
  end

  for (genvar s = 0; s < QUOT_BITS; s++) begin : g_step
    localparam int BI = QUOT_BITS - 1 - s;

    logic [96:0] sh;
    logic [96:0] diff;
    logic        ge;

    assign sh   = {d_rem[s], d_nlo[s][BI]};
    assign ge   = (sh >= {1'b0, divisor});
    assign diff = sh - {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        d_tag[s+1] <= '0;
      end else if (adv) begin
        d_tag[s+1] <= d_tag[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_q[s+1]   <= {d_q[s][QUOT_BITS-2:0], ge};
        d_ovf[s+1] <= d_ovf[s];
      end
    end

    if (s + 1 < QUOT_BITS) begin : g_fwd
      always_ff @(posedge clk) begin
        if (adv) begin
          d_rem[s+1] <= ge ? diff[95:0] : sh[95:0];
          d_nlo[s+1] <= d_nlo[s];
        end
      end
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_tag[QUOT_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      weight    <= d_ovf[QUOT_BITS] ? WEIGHT_MAX : d_q[QUOT_BITS];
      saturated <= d_ovf[QUOT_BITS];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gaussian_projection_weight.sv -----
// ----------------------------------------------------------------------------
// gaussian_projection_weight
// normalized anisotropic gaussian weight of one offset vector per request
// ----------------------------------------------------------------------------
// One request per clock goes in and one result per clock comes out, unless a
// result waits under weight_stall. The depth is set by the two restoring
// dividers, one quotient bit per stage (33 stages for the per-axis ratios, 48
// for the divide by the width product), and the 12-term horner chain at three
// stages a term. The whole pipeline holds while a result waits under
// weight_stall, and offset_stall is high in exactly those cycles. A zero width
// is stored as the smallest width; the width product is computed in registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gaussian_projection_weight import gpw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               offset_valid,
  output logic               offset_stall,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  input  logic signed [31:0] offset_z,
  output logic               weight_valid,
  input  logic               weight_stall,
  output logic        [47:0] weight,
  output logic               saturated,
  input  logic               write_enable,
  input  logic         [1:0] write_index,
  input  logic        [31:0] write_data
);

  gpw_cfg_t    cfg;
  logic [31:0] wdata_eff;
  logic        adv;
  item_tag_t   tag_in;
  item_tag_t   tag_ratio;
  item_tag_t   tag_exp;
  logic [39:0] sum_sq;
  logic [32:0] expo;

  assign wdata_eff = (write_data == '0) ? 32'd1 : write_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.two_d   <= 1'b0;
      cfg.width_x <= WIDTH_RESET;
      cfg.width_y <= WIDTH_RESET;
      cfg.width_z <= WIDTH_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        REG_DIMS:    cfg.two_d   <= (write_data[1:0] == DIMS_2D);
        REG_WIDTH_X: cfg.width_x <= wdata_eff;
        REG_WIDTH_Y: cfg.width_y <= wdata_eff;
        REG_WIDTH_Z: cfg.width_z <= wdata_eff;
      endcase
    end
  end

  // global hold while the output register is full and stalled
  assign adv          = !(weight_valid && weight_stall);
  assign offset_stall = !adv;

  assign tag_in.valid = offset_valid;
  assign tag_in.two_d = cfg.two_d;

  gpw_ratio u_ratio (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .tag_in   (tag_in),
    .offset_x (offset_x),
    .offset_y (offset_y),
    .offset_z (offset_z),
    .cfg      (cfg),
    .tag_out  (tag_ratio),
    .sum_sq   (sum_sq)
  );

  gpw_exp u_exp (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .tag_in  (tag_ratio),
    .sum_sq  (sum_sq),
    .tag_out (tag_exp),
    .expo    (expo)
  );

  gpw_norm_div u_norm_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .tag_in    (tag_exp),
    .expo      (expo),
    .cfg       (cfg),
    .out_valid (weight_valid),
    .weight    (weight),
    .saturated (saturated)
  );

`include "assert_macros.svh"

  `ASSERT_CLK(a_sat_full_scale, weight_valid && saturated |-> weight == WEIGHT_MAX, "saturated result without full-scale weight")
  `ASSERT_CLK(a_widths_nonzero, cfg.width_x != '0 && cfg.width_y != '0 && cfg.width_z != '0, "zero width stored in configuration")
  `ASSERT_ALWAYS(a_reset_clears_output, rst |=> !weight_valid, "result valid right after reset")

endmodule

`default_nettype wire

// ----- sim/gaussian_projection_weight_tb.sv -----
// ----------------------------------------------------------------------------
// gaussian_projection_weight_tb
// self-checking bench for the normalized anisotropic gaussian weight
// ----------------------------------------------------------------------------
// Offset requests are fed from a queue in random bursts. The bench keeps its
// own fixed-point model of the weight, with shadow copies of the dims and
// width registers. Each result is compared with the oldest predicted weight.
// The result side stalls in random patterns. Configuration is rewritten
// between phases, only once the pipeline has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_projection_weight_tb;
  import gpw_pkg::*;

  localparam int LATENCY   = 140;
  localparam int MAX_CYCLE = 2000000;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } offset_t;

  typedef struct {
    logic [47:0] weight;
    logic        saturated;
  } weight_t;

  logic               clk = 0;
  logic               rst = 1;
  logic               offset_valid = 0;
  logic               offset_stall;
  logic signed [31:0] offset_x = 0;
  logic signed [31:0] offset_y = 0;
  logic signed [31:0] offset_z = 0;
  logic               weight_valid;
  logic               weight_stall = 0;
  logic        [47:0] weight;
  logic               saturated;
  logic               write_enable = 0;
  logic         [1:0] write_index = REG_DIMS;
  logic        [31:0] write_data = 0;

  offset_t pending_offsets[$];
  weight_t expected_weights[$];
  logic [1:0]  dims_sh;
  logic [31:0] wx_sh, wy_sh, wz_sh;
  int fail_count = 0;
  int cycle_count = 0;
  bit request_taken = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;

  gaussian_projection_weight u_dut (.*);

  always #2 clk = ~clk;

  function automatic logic [63:0] ratio_squared(logic [31:0] d, logic [31:0] w);
    logic [63:0] mag, r, wd;
    mag = d[31] ? (64'h1_0000_0000 - {32'h0, d}) : {32'h0, d};
    wd = (w == 0) ? 64'd1 : {32'h0, w};
    r = (mag << 28) / wd;
    if (r > (64'd8 << 28)) r = 64'd8 << 28;
    return (r * r) >> 24;
  endfunction

  function automatic logic [63:0] exp_negative(logic [63:0] s);
    logic [63:0] n, rem, acc;
    n = s / 64'hB172_17F8;
    rem = s - n * 64'hB172_17F8;
    acc = 64'h1_0000_0000;
    for (int k = 12; k >= 1; k--)
      acc = 64'h1_0000_0000 - ((rem * acc) >> 32) / k;
    if (n >= 64) return 0;
    return acc >> n;
  endfunction

  function automatic weight_t predict_weight(offset_t o);
    weight_t res;
    logic two_d;
    logic [63:0] s, e, a;
    logic [95:0] num;
    two_d = (dims_sh == DIMS_2D);
    s = ratio_squared(o.x, wx_sh) + ratio_squared(o.y, wy_sh);
    if (!two_d) s += ratio_squared(o.z, wz_sh);
    e = exp_negative(s);
    a = e * (two_d ? 64'd1367130551 : 64'd771320817);
    num = two_d ? {32'h0, a} : ({32'h0, a} << 16);
    // successive floor divides equal one floor divide by the product
    num = num / ((wx_sh == 0) ? 96'd1 : {64'h0, wx_sh});
    num = num / ((wy_sh == 0) ? 96'd1 : {64'h0, wy_sh});
    if (!two_d) num = num / ((wz_sh == 0) ? 96'd1 : {64'h0, wz_sh});
    if (num > {48'h0, WEIGHT_MAX}) begin
      res.weight = WEIGHT_MAX;
      res.saturated = 1;
    end else begin
      res.weight = num[47:0];
      res.saturated = 0;
    end
    return res;
  endfunction

  // request side: bursts of random length with random gaps
  always @(negedge clk) begin
    if (!rst && (!offset_valid || request_taken)) begin
      request_taken = 0;
      if (gap_left > 0) begin
        gap_left--;
        offset_valid <= 0;
      end else if (pending_offsets.size() > 0) begin
        offset_t o;
        o = pending_offsets.pop_front();
        offset_x <= o.x;
        offset_y <= o.y;
        offset_z <= o.z;
        offset_valid <= 1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        offset_valid <= 0;
      end
    end
  end

  // result side stall pattern
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: weight_stall <= 0;
      1: weight_stall <= ($urandom_range(0, 3) == 0);
      2: weight_stall <= ($urandom_range(0, 1) == 1);
      default: weight_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLE) begin
      $display("gaussian_projection_weight: mismatch");
      $finish;
    end
    if (!rst && offset_valid && !offset_stall) begin
      offset_t o;
      o.x = offset_x;
      o.y = offset_y;
      o.z = offset_z;
      expected_weights.push_back(predict_weight(o));
      request_taken = 1;
    end
    if (!rst && weight_valid && !weight_stall) begin
      if (expected_weights.size() == 0) begin
        $display("%0t: unexpected result weight=%h saturated=%b", $time, weight, saturated);
        fail_count++;
      end else begin
        weight_t w;
        w = expected_weights.pop_front();
        if (w.weight !== weight || w.saturated !== saturated) begin
          $display("%0t: expected weight=%h saturated=%b, actual weight=%h saturated=%b",
                   $time, w.weight, w.saturated, weight, saturated);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    write_enable <= 1;
    write_index <= idx;
    write_data <= val;
    @(negedge clk);
    write_enable <= 0;
    case (idx)
      REG_DIMS:    dims_sh = val[1:0];
      REG_WIDTH_X: wx_sh = val;
      REG_WIDTH_Y: wy_sh = val;
      default:     wz_sh = val;
    endcase
  endtask

  task automatic drain();
    wait (pending_offsets.size() == 0 && !offset_valid && expected_weights.size() == 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_offset(logic [31:0] w);
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(0, 31);
      default: v = $urandom_range(0, (w >> 1) * 3 + 1);
    endcase
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [31:0] rand_width();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 4096);
      default: return $urandom_range(32'h0000_2000, 32'h0010_0000);
    endcase
  endfunction

  task automatic random_phase(logic [1:0] d, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, int count);
    offset_t o;
    write_reg(REG_DIMS, {30'b0, d});
    write_reg(REG_WIDTH_X, x);
    write_reg(REG_WIDTH_Y, y);
    write_reg(REG_WIDTH_Z, z);
    for (int i = 0; i < count; i++) begin
      o.x = rand_offset(x);
      o.y = rand_offset(y);
      o.z = rand_offset(z);
      pending_offsets.push_back(o);
    end
    drain();
  endtask

  initial begin
    logic [31:0] edge_vals [8];
    offset_t o;
    dims_sh = 2'd3;
    wx_sh = WIDTH_RESET;
    wy_sh = WIDTH_RESET;
    wz_sh = WIDTH_RESET;
    edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0001_0000, 32'hFFFF_0000, 32'h0002_C000};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // reset config, corner offsets including the ratio cap
    for (int i = 0; i < 8; i++) begin
      o.x = edge_vals[i];
      o.y = edge_vals[(i + 3) % 8];
      o.z = edge_vals[(i + 5) % 8];
      pending_offsets.push_back(o);
    end
    drain();
    // tiny widths saturate, zero width acts as the smallest width; then the largest widths
    random_phase(2'd3, 32'h0, 32'h1, 32'h0, 8);
    random_phase(DIMS_2D, 32'h1, 32'h0, 32'hFFFF_FFFF, 8);
    random_phase(DIMS_2D, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 8);
    random_phase(2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8);
    random_phase(2'd1, 32'h0001_0000, 32'h0000_8000, 32'h0004_0000, 100);
    random_phase(DIMS_2D, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 150);
    for (int p = 0; p < 12; p++)
      random_phase(2'($urandom_range(0, 3)), rand_width(), rand_width(), rand_width(), 130);

    if (fail_count == 0) begin
      $display("gaussian_projection_weight: match");
    end else begin
      $display("gaussian_projection_weight: mismatch");
    end
    $finish;
  end

endmodule

// ----- gaussian_projection_weight.f -----
+incdir+hw/rtl
hw/rtl/gpw_pkg.sv
hw/rtl/gpw_ratio.sv
hw/rtl/gpw_exp.sv
hw/rtl/gpw_norm_div.sv
hw/rtl/gaussian_projection_weight.sv
sim/gaussian_projection_weight_tb.sv
